// File: hdl/sfp_pkg.sv
// Shared types, constants and codes of the sum-checked frame parser.
package sfp_pkg;

    // Payload store geometry
    localparam int MAX_PAYLOAD = 32;
    localparam int STORE_DEPTH = 32;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int SIZE_LIMIT  = (MAX_PAYLOAD < STORE_DEPTH) ? MAX_PAYLOAD : STORE_DEPTH;
    localparam int SIZE_W      = 6;
    localparam int POS_W       = 5;

    // Framing overhead: header, command, length, checksum, tail
    localparam int FRAME_OVERHEAD = 5;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAIL        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_LENGTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_CMD   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_SIZE  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_CMD  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_SIZE = 3'd6;

    // Configuration reset values
    localparam logic [7:0]        RST_HEADER      = 8'd165;
    localparam logic [7:0]        RST_TAIL        = 8'd90;
    localparam logic [7:0]        RST_MIN_LENGTH  = 8'd5;
    localparam logic [7:0]        RST_FIRST_CMD   = 8'd1;
    localparam logic [SIZE_W-1:0] RST_FIRST_SIZE  = 6'd16;
    localparam logic [7:0]        RST_SECOND_CMD  = 8'd2;
    localparam logic [SIZE_W-1:0] RST_SECOND_SIZE = 6'd16;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_FRAMING   = 3'd2;
    localparam logic [2:0] ST_CHECKSUM  = 3'd3;
    localparam logic [2:0] ST_CMD_LEN   = 3'd4;

    // One received byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } sfp_in_t;

    // One result item
    typedef struct packed {
        logic [2:0]       status;
        logic             command_valid;
        logic [7:0]       command_byte;
        logic [7:0]       payload_value;
        logic [POS_W-1:0] payload_position;
        logic             run_end;
    } sfp_out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic byte_accept;   // store a non-final byte
        logic frame_end;     // latch the verdict and clear the frame state
        logic read_issue;    // read the store at the replay position
        logic load_fail;     // load the status result into the output register
        logic load_data;     // load one payload result and advance the replay
    } sfp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic frame_pass;    // verdict of the byte on the input is success
        logic replay_last;   // replay position is the last payload byte
    } sfp_stat_t;

endpackage

// File: hdl/sfp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; hold data while idle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/sfp_datapath.sv
// Datapath of the frame parser: configuration, frame state, verdict, store and output register.
module sfp_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sfp_pkg::sfp_in_t                  byte_data,
    input  logic                              cfg_write,
    input  logic [sfp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [7:0]                        cfg_data,
    input  sfp_pkg::sfp_cmd_t                 cmd,
    output sfp_pkg::sfp_stat_t                stat,
    output sfp_pkg::sfp_out_t                 result_data
);
    import sfp_pkg::*;

    // Configuration registers
    logic [7:0]        header_reg, tail_reg, min_length_reg;
    logic [7:0]        first_cmd_reg, second_cmd_reg;
    logic [SIZE_W-1:0] first_size_reg, second_size_reg;

    // Frame state
    logic [7:0] count_reg, count_next;
    logic [7:0] first_seen_reg, first_seen_next;
    logic [7:0] cmd_seen_reg, cmd_seen_next;
    logic [7:0] len_seen_reg, len_seen_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] prev_reg, prev_next;

    // Latched verdict and replay
    logic [2:0]        verdict_status_reg;
    logic              verdict_cv_reg;
    logic [7:0]        verdict_cmd_reg;
    logic [SIZE_W-1:0] verdict_size_reg;
    logic [POS_W-1:0]  pos_reg, pos_next;

    // Output register
    sfp_out_t out_reg;

    // Verdict logic
    logic [8:0]        total;
    logic [7:0]        min_len;
    logic [7:0]        frame_first;
    logic              hit_first, hit_second;
    logic [SIZE_W-1:0] size;
    logic              size_ok, len_match, long_enough;
    logic [2:0]        status;
    logic              cv;

    // Store access
    logic [7:0]          wr_off;
    logic                wr_en;
    logic [7:0]          rd_data;
    logic [SIZE_W-1:0]   pos_plus;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg      <= RST_HEADER;
            tail_reg        <= RST_TAIL;
            min_length_reg  <= RST_MIN_LENGTH;
            first_cmd_reg   <= RST_FIRST_CMD;
            first_size_reg  <= RST_FIRST_SIZE;
            second_cmd_reg  <= RST_SECOND_CMD;
            second_size_reg <= RST_SECOND_SIZE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_HEADER:      header_reg      <= cfg_data;
                CFG_TAIL:        tail_reg        <= cfg_data;
                CFG_MIN_LENGTH:  min_length_reg  <= cfg_data;
                CFG_FIRST_CMD:   first_cmd_reg   <= cfg_data;
                CFG_FIRST_SIZE:  first_size_reg  <= cfg_data[SIZE_W-1:0];
                CFG_SECOND_CMD:  second_cmd_reg  <= cfg_data;
                CFG_SECOND_SIZE: second_size_reg <= cfg_data[SIZE_W-1:0];
                default:         ;
            endcase
        end
    end

    // Judge the frame on its final byte
    always_comb
    begin
        total       = (count_reg == 8'd255) ? 9'd255 : {1'b0, count_reg} + 9'd1;
        min_len     = (min_length_reg < 8'(FRAME_OVERHEAD)) ? 8'(FRAME_OVERHEAD)
                                                            : min_length_reg;
        frame_first = (count_reg == 8'd0) ? byte_data.data_byte : first_seen_reg;
        hit_first   = (cmd_seen_reg == first_cmd_reg);
        hit_second  = (cmd_seen_reg == second_cmd_reg);
        if (hit_first)
        begin
            size = first_size_reg;
        end
        else if (hit_second)
        begin
            size = second_size_reg;
        end
        else
        begin
            size = '0;
        end
        len_match   = (hit_first || hit_second) && (len_seen_reg == 8'(size));
        size_ok     = (size != '0) && (size <= SIZE_W'(SIZE_LIMIT));
        long_enough = (total >= 9'(size) + 9'(FRAME_OVERHEAD));
        cv          = 1'b0;
        priority if (total < 9'(min_len))
        begin
            status = ST_SHORT;
        end
        else if (frame_first != header_reg || byte_data.data_byte != tail_reg)
        begin
            status = ST_FRAMING;
        end
        else if (prev_reg != sum_reg)
        begin
            status = ST_CHECKSUM;
        end
        else
        begin
            cv     = 1'b1;
            status = (len_match && size_ok && long_enough) ? ST_OK : ST_CMD_LEN;
        end
    end

    // Advance the frame state
    always_comb
    begin
        count_next      = count_reg;
        first_seen_next = first_seen_reg;
        cmd_seen_next   = cmd_seen_reg;
        len_seen_next   = len_seen_reg;
        sum_next        = sum_reg;
        prev_next       = prev_reg;
        if (cmd.frame_end)
        begin
            count_next      = '0;
            first_seen_next = '0;
            cmd_seen_next   = '0;
            len_seen_next   = '0;
            sum_next        = '0;
            prev_next       = '0;
        end
        else if (cmd.byte_accept)
        begin
            if (count_reg == 8'd0)
            begin
                first_seen_next = byte_data.data_byte;
            end
            if (count_reg == 8'd1)
            begin
                cmd_seen_next = byte_data.data_byte;
            end
            if (count_reg == 8'd2)
            begin
                len_seen_next = byte_data.data_byte;
            end
            if (count_reg != 8'd0)
            begin
                sum_next = sum_reg + prev_reg;
            end
            prev_next = byte_data.data_byte;
            if (count_reg != 8'd255)
            begin
                count_next = count_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            first_seen_reg <= '0;
            cmd_seen_reg   <= '0;
            len_seen_reg   <= '0;
            sum_reg        <= '0;
            prev_reg       <= '0;
            pos_reg        <= '0;
        end
        else
        begin
            count_reg      <= count_next;
            first_seen_reg <= first_seen_next;
            cmd_seen_reg   <= cmd_seen_next;
            len_seen_reg   <= len_seen_next;
            sum_reg        <= sum_next;
            prev_reg       <= prev_next;
            pos_reg        <= pos_next;
        end
    end

    // Latch the verdict when the frame ends
    always_ff @(posedge clk)
    begin
        if (cmd.frame_end)
        begin
            verdict_status_reg <= status;
            verdict_cv_reg     <= cv;
            verdict_cmd_reg    <= cv ? cmd_seen_reg : 8'd0;
            verdict_size_reg   <= size;
        end
    end

    // Store payload bytes that fit
    assign wr_off = count_reg - 8'd3;
    assign wr_en  = cmd.byte_accept && (count_reg >= 8'd3) && (count_reg != 8'd255)
                    && (wr_off < 8'(SIZE_LIMIT));

    sfp_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_off[STORE_AW-1:0]),
        .wr_data (byte_data.data_byte),
        .rd_en   (cmd.read_issue),
        .rd_addr (pos_reg[STORE_AW-1:0]),
        .rd_data (rd_data)
    );

    // Advance the replay; return to zero after the last byte
    assign pos_plus = SIZE_W'(pos_reg) + 6'd1;

    always_comb
    begin
        pos_next = pos_reg;
        if (cmd.load_data)
        begin
            pos_next = (pos_plus == verdict_size_reg) ? '0 : pos_plus[POS_W-1:0];
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_fail)
        begin
            out_reg.status           <= verdict_status_reg;
            out_reg.command_valid    <= verdict_cv_reg;
            out_reg.command_byte     <= verdict_cmd_reg;
            out_reg.payload_value    <= '0;
            out_reg.payload_position <= '0;
            out_reg.run_end          <= 1'b1;
        end
        else if (cmd.load_data)
        begin
            out_reg.status           <= ST_OK;
            out_reg.command_valid    <= 1'b1;
            out_reg.command_byte     <= verdict_cmd_reg;
            out_reg.payload_value    <= rd_data;
            out_reg.payload_position <= pos_reg;
            out_reg.run_end          <= (pos_plus == verdict_size_reg);
        end
    end

    assign result_data      = out_reg;
    assign stat.frame_pass  = (status == ST_OK);
    assign stat.replay_last = (pos_plus == verdict_size_reg);

endmodule

// File: hdl/sfp_ctrl.sv
// Controller of the frame parser: input and output handshakes and the replay sequence.
module sfp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    input  logic               last_byte,
    output logic               byte_stall,
    output logic               result_valid,
    input  logic               result_stall,
    input  sfp_pkg::sfp_stat_t stat,
    output sfp_pkg::sfp_cmd_t  cmd
);
    import sfp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FAIL,
        S_READ,
        S_SHOW
    } state_t;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;
    logic   accept;
    logic   out_free;

    assign byte_stall   = (state_reg != S_IDLE);
    assign accept       = byte_valid && !byte_stall;
    assign out_free     = !valid_reg || !result_stall;
    assign result_valid = valid_reg;

    // Sequence one frame's results
    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg && result_stall;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && !last_byte)
                begin
                    cmd.byte_accept = 1'b1;
                end
                else if (accept)
                begin
                    cmd.frame_end = 1'b1;
                    state_next    = stat.frame_pass ? S_READ : S_FAIL;
                end
            end
            S_FAIL:
            begin
                if (out_free)
                begin
                    cmd.load_fail = 1'b1;
                    valid_next    = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.read_issue = 1'b1;
                state_next     = S_SHOW;
            end
            S_SHOW:
            begin
                if (out_free)
                begin
                    cmd.load_data = 1'b1;
                    valid_next    = 1'b1;
                    state_next    = stat.replay_last ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// File: hdl/sum_checked_frame_parser.sv
// Top level of the sum-checked frame parser.
// Takes a frame one byte per transfer (last_byte marks the final byte): header,
// command, length, payload, checksum (mod-256 sum of all earlier bytes), tail.
// The parser takes non-final bytes back to back.
// The final byte is judged in the cycle it arrives; a failed frame yields one
// status result through the S_FAIL state, and a good frame replays its payload from
// the store, each byte read in S_READ and loaded in S_SHOW since the store's read
// port is registered, so the input stays stalled until the last payload byte is loaded.
// Configuration writes are always taken (ready stays high) and belong between frames.
module sum_checked_frame_parser (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            byte_valid,
    output logic                            byte_stall,
    input  sfp_pkg::sfp_in_t                byte_data,
    output logic                            result_valid,
    input  logic                            result_stall,
    output sfp_pkg::sfp_out_t               result_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sfp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                      cfg_data
);
    import sfp_pkg::*;

    sfp_cmd_t  cmd;
    sfp_stat_t stat;

    assign cfg_ready = 1'b1;

    sfp_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .last_byte    (byte_data.last_byte),
        .byte_stall   (byte_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    sfp_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_data   (byte_data),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .stat        (stat),
        .result_data (result_data)
    );

endmodule

// File: sim/tb.sv
// Self-checking testbench for the sum-checked frame parser.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfp_pkg::*;

    // Index past the end of the register list; writes to it are dropped
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;

    // One full register setting, in register index order
    typedef struct packed {
        logic [7:0] header;
        logic [7:0] tail;
        logic [7:0] min_len;
        logic [7:0] cmd_a;
        logic [7:0] size_a;
        logic [7:0] cmd_b;
        logic [7:0] size_b;
    } reg_set_t;

    // One directed frame: layout knobs plus an optional hand-written verdict
    typedef struct packed {
        logic [1:0] setting;
        logic [7:0] hdr;
        logic [7:0] cmd;
        logic [7:0] len;
        logic [8:0] pay_n;
        logic [7:0] skew;
        logic [7:0] tl;
        logic [8:0] cut;
        logic       typed;
        logic [2:0] st;
        logic       cv;
    } frame_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   byte_valid;
    logic                   byte_stall;
    sfp_in_t                byte_data;
    logic                   result_valid;
    logic                   result_stall;
    sfp_out_t               result_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [7:0]             cfg_data;

    // Mirror of the parser's registers and frame state
    reg_set_t cfg_mirror = '{RST_HEADER, RST_TAIL, RST_MIN_LENGTH, RST_FIRST_CMD,
                             8'(RST_FIRST_SIZE), RST_SECOND_CMD, 8'(RST_SECOND_SIZE)};
    logic [7:0] rx_count = '0;
    logic [7:0] rx_first = '0;
    logic [7:0] rx_cmd   = '0;
    logic [7:0] rx_len   = '0;
    logic [7:0] rx_sum   = '0;
    logic [7:0] rx_prev  = '0;
    logic [7:0] rx_store [STORE_DEPTH];

    sfp_out_t    expected_results [$];
    int unsigned mismatch_count = 0;
    int unsigned bytes_sent = 0;
    bit          quiet = 1'b0;

    frame_row_t dir_rows [20];
    reg_set_t   dir_settings [1:3];

    sum_checked_frame_parser u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Advance the frame mirror by one byte; on the final byte return its results
    function automatic void parse_byte(input sfp_in_t item, output sfp_out_t made [$]);
        logic [7:0]  b;
        logic [7:0]  first;
        logic [2:0]  verdict;
        logic        cmd_ok;
        bit          match;
        int unsigned total;
        int unsigned floor_len;
        int unsigned size;
        sfp_out_t    r;
        made = {};
        b = item.data_byte;
        if (!item.last_byte)
        begin
            if (rx_count == 8'd0)
                rx_first = b;
            else if (rx_count == 8'd1)
                rx_cmd = b;
            else if (rx_count == 8'd2)
                rx_len = b;
            else if (rx_count != 8'd255 && int'(rx_count) - 3 < SIZE_LIMIT)
                rx_store[int'(rx_count) - 3] = b;
            if (rx_count != 8'd0)
                rx_sum = rx_sum + rx_prev;
            rx_prev = b;
            if (rx_count != 8'd255)
                rx_count = rx_count + 8'd1;
            return;
        end

        // Judge the frame against the state as it stands
        total     = (rx_count != 8'd255) ? int'(rx_count) + 1 : 255;
        floor_len = (cfg_mirror.min_len < FRAME_OVERHEAD) ? FRAME_OVERHEAD
                                                          : int'(cfg_mirror.min_len);
        first     = (rx_count == 8'd0) ? b : rx_first;
        cmd_ok    = 1'b0;
        match     = 1'b0;
        size      = 0;
        if (total < floor_len)
            verdict = ST_SHORT;
        else if (first != cfg_mirror.header || b != cfg_mirror.tail)
            verdict = ST_FRAMING;
        else if (rx_prev != rx_sum)
            verdict = ST_CHECKSUM;
        else
        begin
            cmd_ok = 1'b1;
            if (rx_cmd == cfg_mirror.cmd_a)
            begin
                size  = cfg_mirror.size_a;
                match = (rx_len == size);
            end
            else if (rx_cmd == cfg_mirror.cmd_b)
            begin
                size  = cfg_mirror.size_b;
                match = (rx_len == size);
            end
            verdict = (match && size >= 1 && size <= SIZE_LIMIT
                       && total >= size + FRAME_OVERHEAD) ? ST_OK : ST_CMD_LEN;
        end

        if (verdict != ST_OK)
        begin
            r = '0;
            r.status        = verdict;
            r.command_valid = cmd_ok;
            r.command_byte  = cmd_ok ? rx_cmd : 8'h00;
            r.run_end       = 1'b1;
            made.push_back(r);
        end
        else
        begin
            for (int p = 0; p < size; p++)
            begin
                r.status           = ST_OK;
                r.command_valid    = 1'b1;
                r.command_byte     = rx_cmd;
                r.payload_value    = rx_store[p];
                r.payload_position = POS_W'(p);
                r.run_end          = (p + 1 == size);
                made.push_back(r);
            end
        end

        // Clear the per-frame state
        rx_count = '0;
        rx_first = '0;
        rx_cmd   = '0;
        rx_len   = '0;
        rx_sum   = '0;
        rx_prev  = '0;
    endfunction

    // Lay out header, command, length, payload, checksum and tail
    function automatic void build_frame(input logic [7:0] hdr, input logic [7:0] cmd,
                                        input logic [7:0] len, input int pay_n,
                                        input logic [7:0] skew, input logic [7:0] tl,
                                        input int cut, output logic [7:0] bytes [$]);
        logic [7:0] sum;
        bytes = {hdr, cmd, len};
        for (int i = 0; i < pay_n; i++)
            bytes.push_back(8'($urandom));
        sum = '0;
        foreach (bytes[i])
            sum = sum + bytes[i];
        bytes.push_back(sum + skew);
        bytes.push_back(tl);
        if (cut > 0)
            while (bytes.size() > cut)
                void'(bytes.pop_back());
    endfunction

    function automatic logic [7:0] pick_size();
        case ($urandom_range(9))
            0:       return 8'($urandom);
            1:       return 8'($urandom_range(32, 7));
            default: return 8'($urandom_range(6, 1));
        endcase
    endfunction

    function automatic reg_set_t random_setting();
        reg_set_t s;
        s.header = 8'($urandom);
        s.tail   = 8'($urandom);
        case ($urandom_range(9))
            0:       s.min_len = 8'($urandom_range(4));
            1:       s.min_len = 8'($urandom_range(40, 11));
            default: s.min_len = 8'($urandom_range(10, 5));
        endcase
        s.cmd_a  = 8'($urandom);
        s.cmd_b  = ($urandom_range(9) == 0) ? s.cmd_a : 8'($urandom);
        s.size_a = pick_size();
        s.size_b = pick_size();
        return s;
    endfunction

    // Predict, then offer one byte and hold it until the transfer
    task automatic send_byte(input sfp_in_t item, input bit use_typed,
                             input sfp_out_t typed_res);
        sfp_out_t made [$];
        parse_byte(item, made);
        if (use_typed && item.last_byte)
            expected_results.push_back(typed_res);
        else
            foreach (made[k])
                expected_results.push_back(made[k]);
        while (!quiet && $urandom_range(99) < 11)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= item;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] bytes [$], input bit use_typed,
                              input sfp_out_t typed_res);
        sfp_in_t item;
        foreach (bytes[i])
        begin
            item.data_byte = bytes[i];
            item.last_byte = (i == bytes.size() - 1);
            send_byte(item, use_typed, typed_res);
        end
    endtask

    // Write one register; cfg_valid stays high for a following write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_HEADER:      cfg_mirror.header  = val;
            CFG_TAIL:        cfg_mirror.tail    = val;
            CFG_MIN_LENGTH:  cfg_mirror.min_len = val;
            CFG_FIRST_CMD:   cfg_mirror.cmd_a   = val;
            CFG_FIRST_SIZE:  cfg_mirror.size_a  = val & 8'h3F;
            CFG_SECOND_CMD:  cfg_mirror.cmd_b   = val;
            CFG_SECOND_SIZE: cfg_mirror.size_b  = val & 8'h3F;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input reg_set_t s);
        write_reg(CFG_HEADER, s.header);
        write_reg(CFG_TAIL, s.tail);
        write_reg(CFG_MIN_LENGTH, s.min_len);
        write_reg(CFG_FIRST_CMD, s.cmd_a);
        write_reg(CFG_FIRST_SIZE, s.size_a);
        write_reg(CFG_SECOND_CMD, s.cmd_b);
        write_reg(CFG_SECOND_SIZE, s.size_b);
        write_reg(CFG_UNUSED, 8'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Drop valid and let every outstanding result drain
    task automatic settle();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // Mostly well-formed frames for the current setting, the rest broken or noise
    task automatic send_random_frame();
        logic [7:0] bytes [$];
        logic [7:0] hdr;
        logic [7:0] tl;
        logic [7:0] cmd;
        logic [7:0] len;
        logic [7:0] skew;
        int         pay_n;
        int         cut;
        int         size;
        int         pick;
        sfp_out_t   none;
        none = '0;
        pick = $urandom_range(99);
        hdr  = cfg_mirror.header;
        tl   = cfg_mirror.tail;
        if ($urandom_range(1))
        begin
            cmd  = cfg_mirror.cmd_a;
            size = cfg_mirror.size_a;
        end
        else
        begin
            cmd  = cfg_mirror.cmd_b;
            size = cfg_mirror.size_b;
        end
        len   = 8'(size);
        skew  = '0;
        cut   = 0;
        pay_n = (size > SIZE_LIMIT) ? $urandom_range(4) : size;
        // pad so that the minimum length does not reject a good frame
        if (pay_n + FRAME_OVERHEAD < cfg_mirror.min_len)
            pay_n = cfg_mirror.min_len - FRAME_OVERHEAD;
        if (pick >= 70 && pick < 78)
            skew = 8'($urandom_range(255, 1));
        else if (pick >= 78 && pick < 84)
        begin
            if ($urandom_range(1))
                hdr = hdr ^ 8'($urandom_range(255, 1));
            else
                tl = tl ^ 8'($urandom_range(255, 1));
        end
        else if (pick >= 84 && pick < 90)
            len = len + 8'($urandom_range(3, 1));
        else if (pick >= 90 && pick < 95)
            cut = $urandom_range(pay_n + FRAME_OVERHEAD - 1, 1);
        build_frame(hdr, cmd, len, pay_n, skew, tl, cut, bytes);
        if (pick >= 95)
        begin
            bytes = {};
            repeat ($urandom_range(8, 1))
                bytes.push_back(8'($urandom));
        end
        send_frame(bytes, 1'b0, none);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin : check_results
        sfp_out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result %p arrived, expected none", $time, result_data);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status", want.status, result_data.status);
                check_field("command_valid", want.command_valid, result_data.command_valid);
                check_field("command_byte", want.command_byte, result_data.command_byte);
                check_field("payload_value", want.payload_value, result_data.payload_value);
                check_field("payload_position", want.payload_position,
                            result_data.payload_position);
                check_field("run_end", want.run_end, result_data.run_end);
            end
        end
    end

    // Result side: random stalls, one long hold-off that backs up the input
    initial
    begin : result_sink
        int unsigned taken;
        int unsigned hold_left;
        bit          held_once;
        taken     = 0;
        hold_left = 0;
        held_once = 1'b0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
                taken++;
            if (!held_once && taken >= 40)
            begin
                held_once = 1'b1;
                hold_left = 400;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= !quiet && ($urandom_range(99) < 11);
        end
    end

    initial
    begin
        #1_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        frame_row_t  row;
        logic [7:0]  bytes [$];
        sfp_out_t    typed_res;
        logic [1:0]  cur;
        int unsigned phase_start;

        // setting: hdr, tail, min_len, cmd_a, size_a, cmd_b, size_b
        dir_settings[1] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h01, 8'hFF, 8'h20};
        dir_settings[2] = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h80, 8'hFF};
        dir_settings[3] = '{8'hFF, 8'h00, 8'h05, 8'h7F, 8'h20, 8'h00, 8'h01};

        // setting, hdr, cmd, len, pay_n, skew, tail, cut, typed, status, cmd valid
        dir_rows = '{
            // reset setting: every failure kind, both commands
            '{2'd0, 8'hFF, 8'h00, 8'h00, 9'd0,   8'h00, 8'h5A, 9'd1, 1'b1, ST_SHORT,    1'b0},
            '{2'd0, 8'hA5, 8'h01, 8'h10, 9'd16,  8'h00, 8'h5A, 9'd4, 1'b1, ST_SHORT,    1'b0},
            '{2'd0, 8'h00, 8'h01, 8'h00, 9'd0,   8'h00, 8'h5A, 9'd0, 1'b1, ST_FRAMING,  1'b0},
            '{2'd0, 8'hA5, 8'h01, 8'h00, 9'd0,   8'h00, 8'hFF, 9'd0, 1'b1, ST_FRAMING,  1'b0},
            '{2'd0, 8'hA5, 8'h01, 8'h10, 9'd0,   8'h01, 8'h5A, 9'd0, 1'b1, ST_CHECKSUM, 1'b0},
            '{2'd0, 8'hA5, 8'h01, 8'h10, 9'd16,  8'h00, 8'h5A, 9'd0, 1'b0, ST_OK,       1'b1},
            '{2'd0, 8'hA5, 8'h02, 8'h10, 9'd16,  8'h00, 8'h5A, 9'd0, 1'b0, ST_OK,       1'b1},
            '{2'd0, 8'hA5, 8'h03, 8'h00, 9'd0,   8'h00, 8'h5A, 9'd0, 1'b1, ST_CMD_LEN,  1'b1},
            // frame too short to hold its declared payload, then a length that differs from the size
            '{2'd0, 8'hA5, 8'h01, 8'h10, 9'd2,   8'h00, 8'h5A, 9'd0, 1'b1, ST_CMD_LEN,  1'b1},
            '{2'd0, 8'hA5, 8'h01, 8'h0F, 9'd0,   8'h00, 8'h5A, 9'd0, 1'b1, ST_CMD_LEN,  1'b1},
            // equal commands, low minimum length
            '{2'd1, 8'h00, 8'hFF, 8'h01, 9'd1,   8'h00, 8'hFF, 9'd0, 1'b0, ST_OK,       1'b1},
            '{2'd1, 8'h00, 8'hFF, 8'h20, 9'd0,   8'h00, 8'hFF, 9'd0, 1'b1, ST_CMD_LEN,  1'b1},
            '{2'd1, 8'h00, 8'hFF, 8'h01, 9'd1,   8'h00, 8'hFF, 9'd4, 1'b1, ST_SHORT,    1'b0},
            '{2'd1, 8'h00, 8'hFF, 8'h01, 9'd0,   8'h00, 8'hFF, 9'd0, 1'b1, ST_CMD_LEN,  1'b1},
            // unusable sizes: zero and above the store
            '{2'd2, 8'h00, 8'h00, 8'h00, 9'd0,   8'h00, 8'hFF, 9'd0, 1'b1, ST_CMD_LEN,  1'b1},
            '{2'd2, 8'h00, 8'h80, 8'h3F, 9'd0,   8'h00, 8'hFF, 9'd0, 1'b1, ST_CMD_LEN,  1'b1},
            '{2'd2, 8'h00, 8'h80, 8'h3F, 9'd0,   8'h00, 8'hFF, 9'd4, 1'b1, ST_SHORT,    1'b0},
            // full store, single byte, bytes past the store
            '{2'd3, 8'hFF, 8'h7F, 8'h20, 9'd32,  8'h00, 8'h00, 9'd0, 1'b0, ST_OK,       1'b1},
            '{2'd3, 8'hFF, 8'h00, 8'h01, 9'd1,   8'h00, 8'h00, 9'd0, 1'b0, ST_OK,       1'b1},
            '{2'd3, 8'hFF, 8'h7F, 8'h20, 9'd33,  8'h00, 8'h00, 9'd0, 1'b0, ST_OK,       1'b1}
        };

        // Hold every input at a known value through reset
        rst_n      <= 1'b0;
        byte_valid <= 1'b0;
        byte_data  <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames
        cur = 2'd0;
        foreach (dir_rows[n])
        begin
            row = dir_rows[n];
            if (row.setting != cur)
            begin
                settle();
                cur = row.setting;
                apply_setting(dir_settings[cur]);
            end
            build_frame(row.hdr, row.cmd, row.len, row.pay_n, row.skew, row.tl, row.cut,
                        bytes);
            typed_res               = '0;
            typed_res.status        = row.st;
            typed_res.command_valid = row.cv;
            typed_res.command_byte  = row.cv ? row.cmd : 8'h00;
            typed_res.run_end       = 1'b1;
            send_frame(bytes, row.typed, typed_res);
        end

        // Random frames over several random settings; one longer phase without idling
        for (int ph = 0; ph < 4; ph++)
        begin
            settle();
            apply_setting(random_setting());
            quiet = (ph == 2);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < ((ph == 2) ? 40 : 12))
                send_random_frame();
        end
        quiet = 1'b0;

        settle();
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
hdl/sfp_pkg.sv
hdl/sfp_ram.sv
hdl/sfp_datapath.sv
hdl/sfp_ctrl.sv
hdl/sum_checked_frame_parser.sv
sim/tb.sv
